// File: sv/nlc_pkg.sv
// ============================================================================
// nlc_pkg
// Types, character codes and character-class functions shared by the
// numeric literal classifier.
// ============================================================================
package nlc_pkg;

    // character codes
    localparam logic [7:0] C_NUL     = 8'h00;
    localparam logic [7:0] C_ZERO    = 8'h30;
    localparam logic [7:0] C_NINE    = 8'h39;
    localparam logic [7:0] C_LOW_A   = 8'h61;
    localparam logic [7:0] C_LOW_F   = 8'h66;
    localparam logic [7:0] C_UP_A    = 8'h41;
    localparam logic [7:0] C_UP_F    = 8'h46;
    localparam logic [7:0] C_LOW_X   = 8'h78;
    localparam logic [7:0] C_UP_X    = 8'h58;
    localparam logic [7:0] C_LOW_E   = 8'h65;
    localparam logic [7:0] C_UP_E    = 8'h45;
    localparam logic [7:0] C_DOT     = 8'h2e;
    localparam logic [7:0] C_MINUS   = 8'h2d;
    localparam logic [7:0] C_PLUS    = 8'h2b;

    // integer recogniser states
    typedef enum logic [2:0] {
        IS_START = 3'd0,
        IS_SIGN  = 3'd1,
        IS_ZERO  = 3'd2,
        IS_DEC   = 3'd3,
        IS_HEXX  = 3'd4,
        IS_HEX   = 3'd5,
        IS_FAIL  = 3'd6
    } t_int_state;

    // float recogniser states
    typedef enum logic [3:0] {
        FS_START   = 4'd0,
        FS_SIGN    = 4'd1,
        FS_INT     = 4'd2,
        FS_DOTONLY = 4'd3,
        FS_FRAC    = 4'd4,
        FS_EXP     = 4'd5,
        FS_EXPSIGN = 4'd6,
        FS_EXPDIG  = 4'd7,
        FS_FAIL    = 4'd8
    } t_flt_state;

    // verdicts for one closed string
    typedef struct packed {
        logic integer_ok;
        logic hex_form;
        logic float_ok;
        logic number_ok;
        logic end_of_string;
    } t_result;

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= C_ZERO) && (c <= C_NINE);
    endfunction

    function automatic logic is_hexd(input logic [7:0] c);
        return is_dec(c) || ((c >= C_LOW_A) && (c <= C_LOW_F)) ||
               ((c >= C_UP_A) && (c <= C_UP_F));
    endfunction

    function automatic logic is_sign(input logic [7:0] c);
        return (c == C_MINUS) || (c == C_PLUS);
    endfunction

    function automatic logic is_exp(input logic [7:0] c);
        return (c == C_LOW_E) || (c == C_UP_E);
    endfunction

endpackage

// File: sv/nlc_if.sv
// ============================================================================
// nlc_if
// Valid/ready channels of the numeric literal classifier: byte input,
// verdict output and the configuration write channel.
// ============================================================================

// byte input channel
interface nlc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       empty_string;
    logic       last_byte;

    modport source (output valid, output char_byte, output empty_string,
                    output last_byte, input ready);
    modport sink   (input valid, input char_byte, input empty_string,
                    input last_byte, output ready);
endinterface

// verdict output channel
interface nlc_out_if;
    logic valid;
    logic ready;
    logic integer_ok;
    logic hex_form;
    logic float_ok;
    logic number_ok;
    logic end_of_string;

    modport source (output valid, output integer_ok, output hex_form,
                    output float_ok, output number_ok, output end_of_string,
                    input ready);
    modport sink   (input valid, input integer_ok, input hex_form,
                    input float_ok, input number_ok, input end_of_string,
                    output ready);
endinterface

// configuration write channel
interface nlc_cfg_if;
    logic valid;
    logic ready;
    logic strict_hex_sign;

    modport source (output valid, output strict_hex_sign, input ready);
    modport sink   (input valid, input strict_hex_sign, output ready);
endinterface

// File: sv/nlc_dfa.sv
// ============================================================================
// nlc_dfa
// Integer and float recognisers stepped by one byte per accepted word;
// produces the verdicts when the string closes and returns to start.
// ============================================================================
module nlc_dfa
    import nlc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_char,
    input  logic       i_empty,
    input  logic       i_last,
    input  logic       i_strict,
    output logic       o_close,
    output t_result    o_result
);

    t_int_state r_int_state, n_int_state, int_step;
    t_flt_state r_flt_state, n_flt_state, flt_step;
    logic       r_int_signed, n_int_signed;
    logic       r_term, n_term;
    logic       take_byte;
    logic       int_loose;
    logic       int_strict;
    logic       flt_ok;
    logic       empty_case;

    // integer recogniser step
    always_comb begin
        int_step = IS_FAIL;
        case (r_int_state)
            IS_START, IS_SIGN: begin
                if ((r_int_state == IS_START) && is_sign(i_char)) begin
                    int_step = IS_SIGN;
                end else if (i_char == C_ZERO) begin
                    int_step = IS_ZERO;
                end else if (is_dec(i_char)) begin
                    int_step = IS_DEC;
                end
            end
            IS_ZERO: begin
                if ((i_char == C_LOW_X) || (i_char == C_UP_X)) begin
                    int_step = IS_HEXX;
                end else if (is_dec(i_char)) begin
                    int_step = IS_DEC;
                end
            end
            IS_DEC: begin
                if (is_dec(i_char)) int_step = IS_DEC;
            end
            IS_HEXX, IS_HEX: begin
                if (is_hexd(i_char)) int_step = IS_HEX;
            end
            default: int_step = IS_FAIL;
        endcase
    end

    // float recogniser step
    always_comb begin
        flt_step = FS_FAIL;
        case (r_flt_state)
            FS_START, FS_SIGN: begin
                if ((r_flt_state == FS_START) && is_sign(i_char)) begin
                    flt_step = FS_SIGN;
                end else if (is_dec(i_char)) begin
                    flt_step = FS_INT;
                end else if (i_char == C_DOT) begin
                    flt_step = FS_DOTONLY;
                end
            end
            FS_INT: begin
                if (is_dec(i_char)) begin
                    flt_step = FS_INT;
                end else if (i_char == C_DOT) begin
                    flt_step = FS_FRAC;
                end else if (is_exp(i_char)) begin
                    flt_step = FS_EXP;
                end
            end
            FS_DOTONLY: begin
                if (is_dec(i_char)) flt_step = FS_FRAC;
            end
            FS_FRAC: begin
                if (is_dec(i_char)) begin
                    flt_step = FS_FRAC;
                end else if (is_exp(i_char)) begin
                    flt_step = FS_EXP;
                end
            end
            FS_EXP, FS_EXPSIGN, FS_EXPDIG: begin
                if ((r_flt_state == FS_EXP) && is_sign(i_char)) begin
                    flt_step = FS_EXPSIGN;
                end else if (is_dec(i_char)) begin
                    flt_step = FS_EXPDIG;
                end
            end
            default: flt_step = FS_FAIL;
        endcase
    end

    // state after this byte, before any close
    always_comb begin
        take_byte    = !i_empty && !r_term;
        n_int_state  = r_int_state;
        n_flt_state  = r_flt_state;
        n_int_signed = r_int_signed;
        n_term       = r_term;
        if (take_byte) begin
            if (i_char == C_NUL) begin
                n_term = 1'b1;
            end else begin
                n_int_state = int_step;
                n_flt_state = flt_step;
                if ((r_int_state == IS_START) && is_sign(i_char)) begin
                    n_int_signed = 1'b1;
                end
            end
        end
    end

    // verdicts from the updated state
    always_comb begin
        o_close    = i_empty || i_last;
        empty_case = i_empty && (n_flt_state == FS_START) && !n_term;
        int_loose  = (n_int_state == IS_START) || (n_int_state == IS_ZERO) ||
                     (n_int_state == IS_DEC) || (n_int_state == IS_HEX);
        int_strict = int_loose &&
                     !(i_strict && n_int_signed && (n_int_state == IS_HEX));
        flt_ok     = (n_flt_state == FS_INT) || (n_flt_state == FS_FRAC) ||
                     (n_flt_state == FS_EXPDIG);
        if (empty_case) begin
            o_result.integer_ok = 1'b1;
            o_result.hex_form   = 1'b0;
            o_result.float_ok   = 1'b1;
            o_result.number_ok  = 1'b1;
        end else begin
            o_result.integer_ok = int_strict;
            o_result.hex_form   = int_strict && (n_int_state == IS_HEX);
            o_result.float_ok   = flt_ok;
            o_result.number_ok  = int_loose || flt_ok;
        end
        o_result.end_of_string = 1'b1;
    end

    // recogniser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_state  <= IS_START;
            r_flt_state  <= FS_START;
            r_int_signed <= 1'b0;
            r_term       <= 1'b0;
        end else if (i_accept) begin
            if (o_close) begin
                r_int_state  <= IS_START;
                r_flt_state  <= FS_START;
                r_int_signed <= 1'b0;
                r_term       <= 1'b0;
            end else begin
                r_int_state  <= n_int_state;
                r_flt_state  <= n_flt_state;
                r_int_signed <= n_int_signed;
                r_term       <= n_term;
            end
        end
    end

`ifndef SYNTHESIS
    // a closing word leaves both recognisers at start
    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && o_close |=> (r_int_state == IS_START) &&
        (r_flt_state == FS_START) && !r_term && !r_int_signed)
        else $error("recogniser state not cleared after string close");

    // a sign was seen only if the integer recogniser has left start
    a_sign_moved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_int_signed |-> (r_int_state != IS_START))
        else $error("sign flag set while integer recogniser at start");

    // a sign moves the float recogniser away from start as well
    a_sign_float: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_int_signed |-> (r_flt_state != FS_START))
        else $error("sign flag set while float recogniser at start");

    // hex verdict only with an accepted integer
    a_hex_int: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.hex_form |-> o_result.integer_ok && o_result.number_ok)
        else $error("hex form reported without integer verdict");
`endif

endmodule

// File: sv/numeric_literal_classifier.sv
// ============================================================================
// numeric_literal_classifier
// Byte-stream numeric literal recogniser with verdict output register.
// ============================================================================
// One byte enters per cycle while ready is high: the integer and float
// recognisers step on the accepted word and, on a word flagged last or
// empty, the verdicts are loaded into the output register. A word is
// taken every cycle as long as the output register is empty or is being
// read in the same cycle, so a stalled sink holds the input back only when
// a verdict is waiting. A zero byte ends the text; later bytes of the same
// string are ignored. The strict-hex-sign register is written through the
// configuration channel, which is always ready, and resets to 0.
module numeric_literal_classifier
    import nlc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    nlc_in_if.sink    i_in,
    nlc_out_if.source o_out,
    nlc_cfg_if.sink   i_cfg
);

    logic    r_strict;
    logic    r_out_valid;
    t_result r_result;
    logic    in_accept;
    logic    close;
    t_result result;

    // input handshake
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_accept   = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // recognisers
    nlc_dfa u_dfa (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_char   (i_in.char_byte),
        .i_empty  (i_in.empty_string),
        .i_last   (i_in.last_byte),
        .i_strict (r_strict),
        .o_close  (close),
        .o_result (result)
    );

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strict <= 1'b0;
        end else if (i_cfg.valid) begin
            r_strict <= i_cfg.strict_hex_sign;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && close) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && close) begin
            r_result <= result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.integer_ok    = r_result.integer_ok;
    assign o_out.hex_form      = r_result.hex_form;
    assign o_out.float_ok      = r_result.float_ok;
    assign o_out.number_ok     = r_result.number_ok;
    assign o_out.end_of_string = r_result.end_of_string;

endmodule

// File: tb/tb_numeric_literal_classifier.sv
// ============================================================================
// tb_numeric_literal_classifier
// Self-checking testbench for the numeric literal classifier. A short
// scripted set of strings covers the corner cases. Random literals follow,
// mostly well formed and partly corrupted, under three idle patterns and
// both settings of the strict hex sign register. An in-bench model of the
// two recognisers predicts every verdict that the script does not give,
// and each verdict word is checked field by field.
// ============================================================================
module tb_numeric_literal_classifier;
    import nlc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    // verdicts that can be read straight off the rules
    localparam t_result VERDICT_EMPTY  = 5'b10111;
    localparam t_result VERDICT_REJECT = 5'b00001;
    localparam t_result VERDICT_NUL    = 5'b10011;
    localparam t_result UNTYPED        = 5'b00000;

    typedef struct {
        logic [7:0] ch;
        logic       empty;
        logic       last;
        bit         typed;
        t_result    verdict;
    } t_script_row;

    logic i_clk;
    logic i_rst_n;

    nlc_in_if  in_if ();
    nlc_out_if out_if ();
    nlc_cfg_if cfg_if ();

    numeric_literal_classifier dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // model of the recognisers and the register
    t_int_state int_st      = IS_START;
    t_flt_state flt_st      = FS_START;
    logic       sign_seen   = 1'b0;
    logic       nul_seen    = 1'b0;
    logic       strict_sign = 1'b0;

    t_result verdict_q [$];
    logic [7:0] lit_q [$];

    string dec_digits = "0123456789";
    string hex_digits = "0123456789abcdefABCDEF";
    string lit_chars  = "0123456789+-.eExXaF";

    int  send_idle_pct = 32;
    int  rcv_idle_pct  = 84;
    bit  hold_req      = 1'b0;
    int  words_sent    = 0;
    int  strings_sent  = 0;
    int  verdicts_seen = 0;
    int  ints_seen     = 0;
    int  hex_seen      = 0;
    int  floats_seen   = 0;
    int  stall_cycles  = 0;
    int  mismatches    = 0;

    // scripted corner cases, walked once after reset
    t_script_row script [20] = '{
        '{8'h00,   1'b1, 1'b1, 1'b1, VERDICT_EMPTY},  // empty string
        '{C_PLUS,  1'b0, 1'b1, 1'b1, VERDICT_REJECT}, // bare sign
        '{C_NUL,   1'b0, 1'b1, 1'b1, VERDICT_NUL},    // zero byte first
        '{C_ZERO,  1'b0, 1'b0, 1'b0, UNTYPED},        // 0x1F
        '{C_LOW_X, 1'b0, 1'b0, 1'b0, UNTYPED},
        '{"1",     1'b0, 1'b0, 1'b0, UNTYPED},
        '{C_UP_F,  1'b0, 1'b1, 1'b0, UNTYPED},
        '{C_MINUS, 1'b0, 1'b0, 1'b0, UNTYPED},        // -.5E-9
        '{C_DOT,   1'b0, 1'b0, 1'b0, UNTYPED},
        '{"5",     1'b0, 1'b0, 1'b0, UNTYPED},
        '{C_UP_E,  1'b0, 1'b0, 1'b0, UNTYPED},
        '{C_MINUS, 1'b0, 1'b0, 1'b0, UNTYPED},
        '{"9",     1'b0, 1'b1, 1'b0, UNTYPED},
        '{8'hff,   1'b0, 1'b1, 1'b1, VERDICT_REJECT}, // top byte value
        '{"7",     1'b0, 1'b0, 1'b0, UNTYPED},        // bytes after a zero byte
        '{C_NUL,   1'b0, 1'b0, 1'b0, UNTYPED},
        '{C_LOW_X, 1'b0, 1'b1, 1'b0, UNTYPED},
        '{"9",     1'b0, 1'b0, 1'b0, UNTYPED},        // empty flag closes "9"
        '{8'ha5,   1'b1, 1'b0, 1'b0, UNTYPED},
        '{8'hff,   1'b1, 1'b1, 1'b1, VERDICT_EMPTY}   // empty and last together
    };

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // hard limit on run time
    initial begin
        #2_000_000;
        $display("numeric_literal_classifier verification failed");
        $finish;
    end

    // steps the model on one accepted word, returns 1 when a verdict is due
    function automatic bit classify_word(input logic [7:0] c, input logic e,
                                         input logic l, output t_result v);
        logic digit;
        logic hex_digit;
        logic sign_ch;
        logic exp_ch;
        logic loose;
        logic strict_ok;
        logic flt_ok;
        digit     = c inside {[C_ZERO:C_NINE]};
        hex_digit = c inside {[C_ZERO:C_NINE], [C_LOW_A:C_LOW_F], [C_UP_A:C_UP_F]};
        sign_ch   = c inside {C_PLUS, C_MINUS};
        exp_ch    = c inside {C_LOW_E, C_UP_E};
        v         = UNTYPED;

        // consume the byte unless the text has already ended
        if (!e && !nul_seen) begin
            if (c == C_NUL) begin
                nul_seen = 1'b1;
            end else begin
                case (int_st)
                    IS_START, IS_SIGN: begin
                        if (int_st == IS_START && sign_ch) begin
                            sign_seen = 1'b1;
                            int_st    = IS_SIGN;
                        end else if (c == C_ZERO) begin
                            int_st = IS_ZERO;
                        end else begin
                            int_st = digit ? IS_DEC : IS_FAIL;
                        end
                    end
                    IS_ZERO: begin
                        if (c == C_LOW_X || c == C_UP_X) int_st = IS_HEXX;
                        else int_st = digit ? IS_DEC : IS_FAIL;
                    end
                    IS_DEC:          int_st = digit ? IS_DEC : IS_FAIL;
                    IS_HEXX, IS_HEX: int_st = hex_digit ? IS_HEX : IS_FAIL;
                    default:         int_st = IS_FAIL;
                endcase

                case (flt_st)
                    FS_START, FS_SIGN: begin
                        if (flt_st == FS_START && sign_ch) flt_st = FS_SIGN;
                        else if (digit) flt_st = FS_INT;
                        else flt_st = (c == C_DOT) ? FS_DOTONLY : FS_FAIL;
                    end
                    FS_INT: begin
                        if (digit) flt_st = FS_INT;
                        else if (c == C_DOT) flt_st = FS_FRAC;
                        else flt_st = exp_ch ? FS_EXP : FS_FAIL;
                    end
                    FS_DOTONLY: flt_st = digit ? FS_FRAC : FS_FAIL;
                    FS_FRAC: begin
                        if (digit) flt_st = FS_FRAC;
                        else flt_st = exp_ch ? FS_EXP : FS_FAIL;
                    end
                    FS_EXP, FS_EXPSIGN, FS_EXPDIG: begin
                        if (flt_st == FS_EXP && sign_ch) flt_st = FS_EXPSIGN;
                        else flt_st = digit ? FS_EXPDIG : FS_FAIL;
                    end
                    default: flt_st = FS_FAIL;
                endcase
            end
        end

        if (!e && !l) return 1'b0;

        // verdicts for the closed string
        if (e && flt_st == FS_START && !nul_seen) begin
            loose     = 1'b1;
            strict_ok = 1'b1;
            flt_ok    = 1'b1;
        end else begin
            loose     = int_st inside {IS_START, IS_ZERO, IS_DEC, IS_HEX};
            strict_ok = loose && !(strict_sign && sign_seen && int_st == IS_HEX);
            flt_ok    = flt_st inside {FS_INT, FS_FRAC, FS_EXPDIG};
        end
        v.integer_ok    = strict_ok;
        v.hex_form      = strict_ok && int_st == IS_HEX;
        v.float_ok      = flt_ok;
        v.number_ok     = loose || flt_ok;
        v.end_of_string = 1'b1;

        int_st    = IS_START;
        flt_st    = FS_START;
        sign_seen = 1'b0;
        nul_seen  = 1'b0;
        return 1'b1;
    endfunction

    // offers one word, waits for it to be taken, then books its verdict
    task automatic send_word(input logic [7:0] c, input logic e, input logic l,
                             input bit typed, input t_result typed_v);
        bit      took;
        bit      closes;
        t_result v;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.char_byte    <= c;
        in_if.empty_string <= e;
        in_if.last_byte    <= l;
        do begin
            @(negedge i_clk);
            took = in_if.ready;
            @(posedge i_clk);
        end while (!took);
        words_sent++;
        closes = classify_word(c, e, l, v);
        if (closes) begin
            strings_sent++;
            verdict_q.push_back(typed ? typed_v : v);
        end
    endtask

    task automatic push_chars(input string set, input int n);
        repeat (n) lit_q.push_back(set[$urandom_range(set.len() - 1)]);
    endtask

    // random literal: mostly well formed, some noise and corruption
    task automatic build_literal();
        int form;
        form = $urandom_range(9);
        lit_q.delete();
        if (form < 8 && $urandom_range(2) == 0)
            lit_q.push_back($urandom_range(1) ? C_MINUS : C_PLUS);
        case (form)
            0, 1, 2: push_chars(dec_digits, $urandom_range(5, 1));
            3, 4: begin
                lit_q.push_back(C_ZERO);
                lit_q.push_back($urandom_range(1) ? C_LOW_X : C_UP_X);
                // no digits leaves a bare prefix
                push_chars(hex_digits, $urandom_range(4));
            end
            5, 6, 7: begin
                push_chars(dec_digits, $urandom_range(3));
                if ($urandom_range(3) != 0) lit_q.push_back(C_DOT);
                push_chars(dec_digits, $urandom_range(3));
                if ($urandom_range(1) == 1) begin
                    lit_q.push_back($urandom_range(1) ? C_LOW_E : C_UP_E);
                    if ($urandom_range(1) == 1)
                        lit_q.push_back($urandom_range(1) ? C_MINUS : C_PLUS);
                    push_chars(dec_digits, $urandom_range(2));
                end
            end
            8: repeat ($urandom_range(6, 1)) lit_q.push_back(8'($urandom));
            default: push_chars(lit_chars, $urandom_range(6, 1));
        endcase
        if (lit_q.size() != 0 && $urandom_range(7) == 0)
            lit_q[$urandom_range(lit_q.size() - 1)] = 8'($urandom);
        if ($urandom_range(15) == 0)
            lit_q.insert($urandom_range(lit_q.size()), C_NUL);
    endtask

    // one string: bytes, closed by the last flag or by an empty-flag word
    task automatic send_literal();
        bit close_by_flag;
        build_literal();
        close_by_flag = (lit_q.size() == 0) || ($urandom_range(7) == 0);
        for (int k = 0; k < lit_q.size(); k++)
            send_word(lit_q[k], 1'b0, !close_by_flag && k == lit_q.size() - 1,
                      1'b0, UNTYPED);
        if (close_by_flag)
            send_word(8'($urandom), 1'b1, 1'($urandom), 1'b0, UNTYPED);
    endtask

    task automatic run_random(input int n);
        int target;
        target = words_sent + n;
        while (words_sent < target) send_literal();
    endtask

    // register write once every verdict is out and the block is quiet
    task automatic write_strict(input logic val);
        bit took;
        in_if.valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_if.valid           <= 1'b1;
        cfg_if.strict_hex_sign <= val;
        do begin
            @(negedge i_clk);
            took = cfg_if.ready;
            @(posedge i_clk);
        end while (!took);
        cfg_if.valid <= 1'b0;
        strict_sign  = val;
    endtask

    // verdict sink: random stalls plus one long hold-off on request
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            out_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    function automatic void check_field(input string fld, input logic want,
                                        input logic got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("verdict %0d %s: expected %b, got %b",
                         verdicts_seen, fld, want, got);
        end
    endfunction

    // compare each verdict word with the oldest prediction
    always @(negedge i_clk) begin
        t_result want;
        if (i_rst_n && in_if.valid && !in_if.ready) stall_cycles++;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            verdicts_seen++;
            if (out_if.integer_ok === 1'b1) ints_seen++;
            if (out_if.hex_form === 1'b1)   hex_seen++;
            if (out_if.float_ok === 1'b1)   floats_seen++;
            if (verdict_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("verdict %0d arrived with none expected", verdicts_seen);
            end else begin
                want = verdict_q.pop_front();
                check_field("integer_ok",    want.integer_ok,    out_if.integer_ok);
                check_field("hex_form",      want.hex_form,      out_if.hex_form);
                check_field("float_ok",      want.float_ok,      out_if.float_ok);
                check_field("number_ok",     want.number_ok,     out_if.number_ok);
                check_field("end_of_string", want.end_of_string, out_if.end_of_string);
            end
        end
    end

    // main sequence
    initial begin
        in_if.valid            <= 1'b0;
        in_if.char_byte        <= 8'h00;
        in_if.empty_string     <= 1'b0;
        in_if.last_byte        <= 1'b0;
        cfg_if.valid           <= 1'b0;
        cfg_if.strict_hex_sign <= 1'b0;
        i_rst_n                <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // scripted corner cases with the register at its reset value
        foreach (script[r])
            send_word(script[r].ch, script[r].empty, script[r].last,
                      script[r].typed, script[r].verdict);

        // sender idles lightly, sink heavily
        write_strict(1'b1);
        run_random(700);

        // the other way round
        send_idle_pct = 84;
        rcv_idle_pct  = 32;
        write_strict(1'b0);
        run_random(700);

        // no idling, with one long sink hold-off to fill the block
        send_idle_pct = 0;
        rcv_idle_pct  = 0;
        write_strict(1'b1);
        hold_req = 1'b1;
        run_random(700);

        in_if.valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d words in %0d strings, %0d verdicts: %0d integer (%0d hex), %0d float",
                 words_sent, strings_sent, verdicts_seen, ints_seen, hex_seen, floats_seen);
        $display("strict hex sign run at 0 and 1, input held back for %0d cycles",
                 stall_cycles);
        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("numeric_literal_classifier verification clean");
        end else begin
            $display("numeric_literal_classifier verification failed");
        end
        $finish;
    end

endmodule
